>>> design/aalr_pkg.sv
// Shared types and constants for the antialiased line rasteriser.
package aalr_pkg;

    // Fixed field widths of the line command and the result beat.
    localparam int COORD_W    = 6;
    localparam int POS_W      = 7;
    localparam int ALPHA_W    = 8;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_CANVAS_WIDTH  = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    // Reset value of both canvas registers.
    localparam logic [POS_W-1:0] CANVAS_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_STEP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_run;
        logic issue;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic at_end;
        logic p1_ready;
    } t_status;

endpackage

>>> design/antialiased_line_raster_core.sv
// Top level of the antialiased line rasteriser: configuration registers and block wiring.
//
// Usage: a line command (two endpoints in the tile and a base alpha) is one beat on the
// input channel (i_in_valid / o_in_stall). For every major-axis position along the line,
// from the lower endpoint to the upper one inclusive, one result beat appears on the
// output channel (o_out_valid / i_out_stall), giving the near and far pixel of the
// Wu-style pair, their weights, canvas clip flags and a last-step flag on the final beat.
// Timing: after acceptance a restoring divider forms the slope one quotient bit per cycle.
// Steps are then issued one per cycle while the step stage has room; each result passes
// through the step stage and then the output register. A new command is taken only once
// the previous line has issued all its steps; its division overlaps the drain of the older
// results. When the receiver stalls, the output register holds its beat and one further
// step waits in the step stage; issuing then pauses until room frees. Reset (synchronous,
// active low) empties the pipeline, returns the sequencer to idle and sets both canvas
// registers to 64. The canvas registers sit at byte addresses 0 and 4 of the APB-style
// port, which is always ready; they should be written only while idle.
module antialiased_line_raster_core #(
    parameter int TILE_SIZE = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aalr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [aalr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [aalr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Line command channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [aalr_pkg::COORD_W-1:0]        i_start_x,
    input  logic [aalr_pkg::COORD_W-1:0]        i_start_y,
    input  logic [aalr_pkg::COORD_W-1:0]        i_end_x,
    input  logic [aalr_pkg::COORD_W-1:0]        i_end_y,
    input  logic [aalr_pkg::ALPHA_W-1:0]        i_alpha,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [aalr_pkg::COORD_W-1:0]        o_near_x,
    output logic [aalr_pkg::COORD_W-1:0]        o_near_y,
    output logic [aalr_pkg::POS_W-1:0]          o_far_x,
    output logic [aalr_pkg::POS_W-1:0]          o_far_y,
    output logic [aalr_pkg::ALPHA_W-1:0]        o_near_weight,
    output logic [aalr_pkg::ALPHA_W-1:0]        o_far_weight,
    output logic                                o_near_inside,
    output logic                                o_far_inside,
    output logic                                o_last_step
);

    localparam int PW = aalr_pkg::POS_W;

    // The canvas size registers. Only the low seven bits of a write are kept; the
    // address decode looks at the word index alone.
    logic [PW-1:0] r_canvas_width;
    logic [PW-1:0] r_canvas_height;
    logic          cfg_write;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= aalr_pkg::CANVAS_RESET;
            r_canvas_height <= aalr_pkg::CANVAS_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                aalr_pkg::REG_CANVAS_WIDTH:  r_canvas_width  <= pwdata[PW-1:0];
                aalr_pkg::REG_CANVAS_HEIGHT: r_canvas_height <= pwdata[PW-1:0];
                default: ;
            endcase
        end
    end

    // Reads return the addressed register, zero-extended.
    always_comb begin
        unique case (paddr[2])
            aalr_pkg::REG_CANVAS_WIDTH:
                prdata = {{(aalr_pkg::APB_DATA_W-PW){1'b0}}, r_canvas_width};
            aalr_pkg::REG_CANVAS_HEIGHT:
                prdata = {{(aalr_pkg::APB_DATA_W-PW){1'b0}}, r_canvas_height};
            default:
                prdata = '0;
        endcase
    end

    // The controller sequences load, division and step issue; the datapath does the work.
    aalr_pkg::t_cmd    cmd;
    aalr_pkg::t_status status;

    aalr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    aalr_dp #(
        .TILE_SIZE (TILE_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_alpha         (i_alpha),
        .i_canvas_width  (r_canvas_width),
        .i_canvas_height (r_canvas_height),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_near_x        (o_near_x),
        .o_near_y        (o_near_y),
        .o_far_x         (o_far_x),
        .o_far_y         (o_far_y),
        .o_near_weight   (o_near_weight),
        .o_far_weight    (o_far_weight),
        .o_near_inside   (o_near_inside),
        .o_far_inside    (o_far_inside),
        .o_last_step     (o_last_step)
    );

endmodule

>>> design/aalr_ctrl.sv
// Sequencing state machine: accept a line, run the slope division, issue the steps.
module aalr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  aalr_pkg::t_status i_status,
    output aalr_pkg::t_cmd    o_cmd
);

    aalr_pkg::t_state r_state;
    aalr_pkg::t_state n_state;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aalr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        accept       = 1'b0;
        unique case (r_state)
            aalr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                accept     = i_in_valid;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = aalr_pkg::ST_DIVIDE;
                end
            end
            aalr_pkg::ST_DIVIDE: begin
                o_cmd.div_run = 1'b1;
                if (i_status.div_done) begin
                    n_state = aalr_pkg::ST_STEP;
                end
            end
            aalr_pkg::ST_STEP: begin
                o_cmd.issue = i_status.p1_ready;
                if (i_status.p1_ready && i_status.at_end) begin
                    n_state = aalr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = aalr_pkg::ST_IDLE;
            end
        endcase
    end

    // An accepted line always goes straight into the division.
    a_accept_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == aalr_pkg::ST_DIVIDE))
        else $error("accepted line did not start the division");

    // Issuing the final step returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue && i_status.at_end) |=> (r_state == aalr_pkg::ST_IDLE))
        else $error("sequencer did not return to idle after the last step");

endmodule

>>> design/aalr_dp.sv
// Datapath: endpoint setup, serial slope divider, minor accumulator and result pipeline.
module aalr_dp #(
    parameter int TILE_SIZE = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  aalr_pkg::t_cmd                      i_cmd,
    output aalr_pkg::t_status                   o_status,
    input  logic [aalr_pkg::COORD_W-1:0]        i_start_x,
    input  logic [aalr_pkg::COORD_W-1:0]        i_start_y,
    input  logic [aalr_pkg::COORD_W-1:0]        i_end_x,
    input  logic [aalr_pkg::COORD_W-1:0]        i_end_y,
    input  logic [aalr_pkg::ALPHA_W-1:0]        i_alpha,
    input  logic [aalr_pkg::POS_W-1:0]          i_canvas_width,
    input  logic [aalr_pkg::POS_W-1:0]          i_canvas_height,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [aalr_pkg::COORD_W-1:0]        o_near_x,
    output logic [aalr_pkg::COORD_W-1:0]        o_near_y,
    output logic [aalr_pkg::POS_W-1:0]          o_far_x,
    output logic [aalr_pkg::POS_W-1:0]          o_far_y,
    output logic [aalr_pkg::ALPHA_W-1:0]        o_near_weight,
    output logic [aalr_pkg::ALPHA_W-1:0]        o_far_weight,
    output logic                                o_near_inside,
    output logic                                o_far_inside,
    output logic                                o_last_step
);

    localparam int CW     = aalr_pkg::COORD_W;
    localparam int PW     = aalr_pkg::POS_W;
    localparam int AW     = aalr_pkg::ALPHA_W;
    localparam int DIV_W  = FRAC_BITS + CW;
    localparam int ACC_W  = FRAC_BITS + CW + 1;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam int PROD_W = FRAC_BITS + AW;
    localparam logic [PW-1:0] TILE_LIM = PW'(TILE_SIZE);
    localparam logic [CW-1:0] TILE_MAX = CW'(TILE_SIZE - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    function automatic logic [CW-1:0] sat_coord(input logic [CW-1:0] v);
        return ({1'b0, v} >= TILE_LIM) ? TILE_MAX : v;
    endfunction

    // Exact x / 255 for any x below 65280.
    function automatic logic [AW-1:0] div255(input logic [2*AW-1:0] x);
        logic [2*AW-1:0] t;
        t = x + {8'd0, x[2*AW-1:AW]} + 16'd1;
        return t[2*AW-1:AW];
    endfunction

    // ---------------- setup ----------------
    logic [CW-1:0] sx, sy, ex, ey, adx, ady;
    logic [CW-1:0] maj0, min0, maj1, min1;
    logic [CW-1:0] lo_maj, hi_maj, lo_min, hi_min, dmin;
    logic          swap, neg;

    always_comb begin
        sx   = sat_coord(i_start_x);
        sy   = sat_coord(i_start_y);
        ex   = sat_coord(i_end_x);
        ey   = sat_coord(i_end_y);
        adx  = (sx > ex) ? sx - ex : ex - sx;
        ady  = (sy > ey) ? sy - ey : ey - sy;
        swap = ady > adx;
        maj0 = swap ? sy : sx;
        min0 = swap ? sx : sy;
        maj1 = swap ? ey : ex;
        min1 = swap ? ex : ey;
        if (maj0 > maj1) begin
            lo_maj = maj1; lo_min = min1; hi_maj = maj0; hi_min = min0;
        end else begin
            lo_maj = maj0; lo_min = min0; hi_maj = maj1; hi_min = min1;
        end
        neg  = hi_min < lo_min;
        dmin = neg ? lo_min - hi_min : hi_min - lo_min;
    end

    // ---------------- line state and divider ----------------
    logic [CW-1:0]    r_major_pos, r_major_end, r_dmaj, r_rem;
    logic [ACC_W-1:0] r_accum;
    logic [DIV_W-1:0] r_quo;
    logic [CNT_W-1:0] r_div_cnt;
    logic             r_neg, r_swap;
    logic [AW-1:0]    r_alpha;

    logic [CW:0]      rem_sh, rem_diff;
    logic             rem_ge;
    logic [ACC_W-1:0] mag;
    logic             at_end;

    assign rem_sh   = {r_rem, r_quo[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dmaj};
    assign rem_ge   = rem_sh >= {1'b0, r_dmaj};
    // A zero-length line divides 0 by 0; its slope is defined as zero.
    assign mag      = (r_dmaj == '0) ? '0 : ACC_W'(r_quo);
    assign at_end   = r_major_pos >= r_major_end;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_major_pos <= lo_maj;
            r_major_end <= hi_maj;
            r_accum     <= {1'b0, lo_min, {FRAC_BITS{1'b0}}};
            r_quo       <= {dmin, {FRAC_BITS{1'b0}}};
            r_rem       <= '0;
            r_dmaj      <= hi_maj - lo_maj;
            r_neg       <= neg;
            r_swap      <= swap;
            r_alpha     <= i_alpha;
            r_div_cnt   <= '0;
        end else if (i_cmd.div_run) begin
            r_rem     <= rem_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
            r_quo     <= {r_quo[DIV_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt + 1'b1;
        end else if (i_cmd.issue && !at_end) begin
            r_major_pos <= r_major_pos + 1'b1;
            r_accum     <= r_neg ? r_accum - mag : r_accum + mag;
        end
    end

    // ---------------- step stage ----------------
    logic [CW-1:0]     whole;
    logic [PROD_W-1:0] frac_prod;
    logic [CW-1:0]     s_nx, s_ny;
    logic [PW-1:0]     s_fx, s_fy;

    assign whole     = r_accum[FRAC_BITS +: CW];
    assign frac_prod = {r_accum[FRAC_BITS-1:0], 8'd0} - PROD_W'(r_accum[FRAC_BITS-1:0]);

    always_comb begin
        if (r_swap) begin
            s_nx = whole;
            s_ny = r_major_pos;
            s_fx = {1'b0, whole} + 1'b1;
            s_fy = {1'b0, r_major_pos};
        end else begin
            s_nx = r_major_pos;
            s_ny = whole;
            s_fx = {1'b0, r_major_pos};
            s_fy = {1'b0, whole} + 1'b1;
        end
    end

    logic          r_p1_valid;
    logic [CW-1:0] r_p1_nx, r_p1_ny;
    logic [PW-1:0] r_p1_fx, r_p1_fy;
    logic [AW-1:0] r_p1_frac, r_p1_alpha;
    logic          r_p1_nin, r_p1_fin, r_p1_last;
    logic          out_load, p1_ready;

    assign out_load = r_p1_valid && (!o_out_valid || !i_out_stall);
    assign p1_ready = !r_p1_valid || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (i_cmd.issue) begin
            r_p1_valid <= 1'b1;
        end else if (out_load) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_p1_nx    <= s_nx;
            r_p1_ny    <= s_ny;
            r_p1_fx    <= s_fx;
            r_p1_fy    <= s_fy;
            r_p1_frac  <= frac_prod[FRAC_BITS +: AW];
            r_p1_alpha <= r_alpha;
            r_p1_nin   <= ({1'b0, s_nx} < i_canvas_width) && ({1'b0, s_ny} < i_canvas_height);
            r_p1_fin   <= (s_fx < i_canvas_width) && (s_fy < i_canvas_height);
            r_p1_last  <= at_end;
        end
    end

    // ---------------- output register ----------------
    logic [2*AW-1:0] near_prod, far_prod;
    logic            r_out_valid;

    assign near_prod = (8'd255 - r_p1_frac) * r_p1_alpha;
    assign far_prod  = r_p1_frac * r_p1_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_near_x      <= r_p1_nx;
            o_near_y      <= r_p1_ny;
            o_far_x       <= r_p1_fx;
            o_far_y       <= r_p1_fy;
            o_near_weight <= div255(near_prod);
            o_far_weight  <= div255(far_prod);
            o_near_inside <= r_p1_nin;
            o_far_inside  <= r_p1_fin;
            o_last_step   <= r_p1_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.div_done = (r_div_cnt == CNT_LAST);
    assign o_status.at_end   = at_end;
    assign o_status.p1_ready = p1_ready;

    // A step is only issued into a free (or freeing) step stage.
    a_issue_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> p1_ready)
        else $error("step issued while the step stage was full");

    // The slope is truncated, so the accumulator stays inside the tile.
    a_accum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> !r_accum[ACC_W-1])
        else $error("minor accumulator left the tile");

endmodule

>>> verif/aalr_raster_checker.sv
// Result checker for the antialiased line rasteriser: predicts every pixel-pair beat and compares.
`timescale 1ns / 1ps

module aalr_raster_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port, watched for register writes.
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [aalr_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [aalr_pkg::APB_DATA_W-1:0]     i_pwdata,
    input  logic                                i_pready,
    // Line command channel.
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [aalr_pkg::COORD_W-1:0]        i_start_x,
    input  logic [aalr_pkg::COORD_W-1:0]        i_start_y,
    input  logic [aalr_pkg::COORD_W-1:0]        i_end_x,
    input  logic [aalr_pkg::COORD_W-1:0]        i_end_y,
    input  logic [aalr_pkg::ALPHA_W-1:0]        i_alpha,
    // Result channel.
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [aalr_pkg::COORD_W-1:0]        i_near_x,
    input  logic [aalr_pkg::COORD_W-1:0]        i_near_y,
    input  logic [aalr_pkg::POS_W-1:0]          i_far_x,
    input  logic [aalr_pkg::POS_W-1:0]          i_far_y,
    input  logic [aalr_pkg::ALPHA_W-1:0]        i_near_weight,
    input  logic [aalr_pkg::ALPHA_W-1:0]        i_far_weight,
    input  logic                                i_near_inside,
    input  logic                                i_far_inside,
    input  logic                                i_last_step,
    // Verdict inputs for the top.
    output int                                  o_mismatch_count,
    output int                                  o_pending
);

    localparam int COORD_W     = aalr_pkg::COORD_W;
    localparam int POS_W       = aalr_pkg::POS_W;
    localparam int ALPHA_W     = aalr_pkg::ALPHA_W;
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_MASK   = (1 << FRAC_BITS) - 1;
    localparam int MAX_STEPS   = 64;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [COORD_W-1:0] near_x;
        logic [COORD_W-1:0] near_y;
        logic [POS_W-1:0]   far_x;
        logic [POS_W-1:0]   far_y;
        logic [ALPHA_W-1:0] near_weight;
        logic [ALPHA_W-1:0] far_weight;
        logic               near_inside;
        logic               far_inside;
        logic               last_step;
    } t_pixel_pair;

    t_pixel_pair        expected_pairs[$];
    t_pixel_pair        seen_pair;
    logic [POS_W-1:0]   canvas_w = aalr_pkg::CANVAS_RESET;
    logic [POS_W-1:0]   canvas_h = aalr_pkg::CANVAS_RESET;
    int                 mismatch_count = 0;

    assign seen_pair = {i_near_x, i_near_y, i_far_x, i_far_y, i_near_weight, i_far_weight,
                        i_near_inside, i_far_inside, i_last_step};

    function automatic string describe(input t_pixel_pair p);
        return $sformatf("near (%0d,%0d) w=%0d in=%0b  far (%0d,%0d) w=%0d in=%0b  last=%0b",
                         p.near_x, p.near_y, p.near_weight, p.near_inside,
                         p.far_x, p.far_y, p.far_weight, p.far_inside, p.last_step);
    endfunction

    // Walks one line command and queues the pixel pair of every major-axis step.
    // Six-bit coordinates never exceed the tile, so no saturation is needed.
    function automatic void rasterise_line(input int ax, input int ay, input int bx,
                                           input int by, input int alpha);
        int  adx, ady, maj0, min0, maj1, min1, swap_tmp, dmin, mag, slope;
        int  accum, pos, whole, frac255, nx, ny, fx, fy, steps;
        bit  steep, neg, done;
        t_pixel_pair pair;
        adx   = (ax > bx) ? ax - bx : bx - ax;
        ady   = (ay > by) ? ay - by : by - ay;
        steep = (ady > adx);
        if (steep) begin
            maj0 = ay; min0 = ax; maj1 = by; min1 = bx;
        end else begin
            maj0 = ax; min0 = ay; maj1 = bx; min1 = by;
        end
        if (maj0 > maj1) begin
            swap_tmp = maj0; maj0 = maj1; maj1 = swap_tmp;
            swap_tmp = min0; min0 = min1; min1 = swap_tmp;
        end
        neg   = (min1 < min0);
        dmin  = neg ? min0 - min1 : min1 - min0;
        // Magnitude is truncated before the sign goes on, so the walk never overshoots.
        mag   = (maj1 == maj0) ? 0 : (dmin << FRAC_BITS) / (maj1 - maj0);
        slope = neg ? -mag : mag;
        pos   = maj0;
        accum = min0 << FRAC_BITS;
        steps = 0;
        done  = 1'b0;
        while (!done) begin
            whole   = accum >> FRAC_BITS;
            frac255 = ((accum & FRAC_MASK) * 255) >> FRAC_BITS;
            if (steep) begin
                nx = whole; ny = pos; fx = whole + 1; fy = pos;
            end else begin
                nx = pos; ny = whole; fx = pos; fy = whole + 1;
            end
            pair.near_x      = COORD_W'(nx);
            pair.near_y      = COORD_W'(ny);
            pair.far_x       = POS_W'(fx);
            pair.far_y       = POS_W'(fy);
            pair.near_weight = ALPHA_W'(((255 - frac255) * alpha) / 255);
            pair.far_weight  = ALPHA_W'((frac255 * alpha) / 255);
            pair.near_inside = (nx < canvas_w) && (ny < canvas_h);
            pair.far_inside  = (fx < canvas_w) && (fy < canvas_h);
            pair.last_step   = (pos >= maj1);
            expected_pairs.push_back(pair);
            steps++;
            if (pos >= maj1 || steps >= MAX_STEPS) begin
                done = 1'b1;
            end else begin
                pos++;
                accum += slope;
            end
        end
    endfunction

    function automatic void check_pair();
        t_pixel_pair want;
        if (expected_pairs.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
                $display("Unexpected result beat: %s", describe(seen_pair));
            mismatch_count++;
        end else begin
            want = expected_pairs.pop_front();
            if (want !== seen_pair) begin
                if (mismatch_count < REPORT_LIMIT) begin
                    $display("Result mismatch at %0t", $realtime);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(seen_pair));
                end
                mismatch_count++;
            end
        end
    endfunction

    // Results are checked before the new command is predicted; a beat leaving at the
    // same edge always belongs to an older line.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_pairs.delete();
            canvas_w = aalr_pkg::CANVAS_RESET;
            canvas_h = aalr_pkg::CANVAS_RESET;
        end else begin
            if (i_out_valid && !i_out_stall)
                check_pair();
            if (i_in_valid && !i_in_stall)
                rasterise_line(int'(i_start_x), int'(i_start_y), int'(i_end_x),
                               int'(i_end_y), int'(i_alpha));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    aalr_pkg::REG_CANVAS_WIDTH:  canvas_w = i_pwdata[POS_W-1:0];
                    aalr_pkg::REG_CANVAS_HEIGHT: canvas_h = i_pwdata[POS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending        <= expected_pairs.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

>>> verif/antialiased_line_raster_core_test.sv
// Testbench top for the antialiased line rasteriser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module antialiased_line_raster_core_test;

    localparam int COORD_W    = aalr_pkg::COORD_W;
    localparam int POS_W      = aalr_pkg::POS_W;
    localparam int ALPHA_W    = aalr_pkg::ALPHA_W;
    localparam int APB_ADDR_W = aalr_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = aalr_pkg::APB_DATA_W;

    // The slowest legal run is 320 lines of up to 64 beats each, every beat waiting on
    // a heavily stalling receiver, plus sender gaps and one long hold; the limit is set
    // above what such a run needs.
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_CYCLES     = 300;
    localparam int NUM_PHASES      = 6;
    localparam int LINES_PER_PHASE = 50;
    localparam int PRESSURE_PHASE  = 2;
    localparam int SETTLE_CYCLES   = 20;

    // Receiver behaviour; each mode lasts a random stretch of cycles.
    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   psel        = 1'b0;
    logic                   penable     = 1'b0;
    logic                   pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr       = '0;
    logic [APB_DATA_W-1:0]  pwdata      = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    logic [COORD_W-1:0]     i_start_x   = '0;
    logic [COORD_W-1:0]     i_start_y   = '0;
    logic [COORD_W-1:0]     i_end_x     = '0;
    logic [COORD_W-1:0]     i_end_y     = '0;
    logic [ALPHA_W-1:0]     i_alpha     = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [COORD_W-1:0]     o_near_x;
    logic [COORD_W-1:0]     o_near_y;
    logic [POS_W-1:0]       o_far_x;
    logic [POS_W-1:0]       o_far_y;
    logic [ALPHA_W-1:0]     o_near_weight;
    logic [ALPHA_W-1:0]     o_far_weight;
    logic                   o_near_inside;
    logic                   o_far_inside;
    logic                   o_last_step;

    int       mismatch_count;
    int       pending_pairs;
    int       cycle_count  = 0;
    int       burst_left   = 0;
    bit       gaps_enabled = 1'b1;
    int       hold_token   = 0;
    int       hold_seen    = 0;
    int       hold_left    = 0;
    t_rx_mode rx_mode      = RX_FREE;
    int       rx_mode_left = 0;

    antialiased_line_raster_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_alpha       (i_alpha),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_near_x      (o_near_x),
        .o_near_y      (o_near_y),
        .o_far_x       (o_far_x),
        .o_far_y       (o_far_y),
        .o_near_weight (o_near_weight),
        .o_far_weight  (o_far_weight),
        .o_near_inside (o_near_inside),
        .o_far_inside  (o_far_inside),
        .o_last_step   (o_last_step)
    );

    aalr_raster_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .i_alpha          (i_alpha),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_near_x         (o_near_x),
        .i_near_y         (o_near_y),
        .i_far_x          (o_far_x),
        .i_far_y          (o_far_y),
        .i_near_weight    (o_near_weight),
        .i_far_weight     (o_far_weight),
        .i_near_inside    (o_near_inside),
        .i_far_inside     (o_far_inside),
        .i_last_step      (o_last_step),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_pairs)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog: a run that hangs or loses beats ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL antialiased_line_raster_core");
            $finish;
        end
    end

    // Receiver. It normally wanders between stall patterns of its own; when the stimulus
    // bumps hold_token it holds the output off for a long, counted stretch so that the
    // block fills up and has to stall its input.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(30, 200);
        end else begin
            rx_mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                RX_FREE:     i_out_stall <= 1'b0;
                RX_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: i_out_stall <= ((cycle_count % 5) < 2);
                default:     i_out_stall <= 1'b0;
            endcase
        end
    end

    // Every task below is entered just after a rising edge and returns just after one,
    // so all drives land as nonblocking updates at the clock edge.

    // One register write: a setup phase, then an access phase held until pready, then
    // an idle phase so that back-to-back writes keep a clean setup phase.
    task automatic apb_write(input logic index, input logic [POS_W-1:0] value,
                             input bit junk_upper);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        // The upper data bits are not part of the register, so they may carry noise.
        pwdata  <= ((junk_upper ? APB_DATA_W'($urandom) : '0) >> POS_W << POS_W)
                   | APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one line command and returns at the edge that accepts it. Valid is left high
    // so that a following call simply replaces the payload; a gap or a drain lowers it.
    task automatic offer_line(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                              input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                              input logic [ALPHA_W-1:0] alpha);
        if (gaps_enabled && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        i_in_valid <= 1'b1;
        i_start_x  <= sx;
        i_start_y  <= sy;
        i_end_x    <= ex;
        i_end_y    <= ey;
        i_alpha    <= alpha;
        do @(posedge i_clk); while (o_in_stall);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Stops offering and waits until every predicted beat has come out, then lets the
    // pipeline settle so that the block is idle for a register write.
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_pairs != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Coordinates lean towards the tile edges, where the clipping and far-pixel corner
    // cases live.
    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return COORD_W'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [ALPHA_W-1:0] random_alpha();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return ALPHA_W'($urandom_range(0, 255));
        endcase
    endfunction

    // A quarter of the lines are short, so that many commands pass with little drain time.
    task automatic random_line();
        logic [COORD_W-1:0] sx, sy, ex, ey;
        sx = random_coord();
        sy = random_coord();
        if ($urandom_range(0, 3) == 0) begin
            ex = sx ^ COORD_W'($urandom_range(0, 3));
            ey = sy ^ COORD_W'($urandom_range(0, 3));
        end else begin
            ex = random_coord();
            ey = random_coord();
        end
        offer_line(sx, sy, ex, ey, random_alpha());
    endtask

    // Hand-picked lines: zero length, full-span horizontals and verticals in both
    // directions, exact diagonals (not steep, since the rise does not exceed the run),
    // lines just steep enough to swap axes, rising and falling minor slopes, and alpha
    // at its extremes and alternating bit patterns.
    task automatic directed_lines();
        offer_line(6'd0,  6'd0,  6'd0,  6'd0,  8'd255);
        offer_line(6'd63, 6'd63, 6'd63, 6'd63, 8'd128);
        offer_line(6'd0,  6'd0,  6'd63, 6'd0,  8'd255);
        offer_line(6'd63, 6'd63, 6'd0,  6'd63, 8'd255);
        offer_line(6'd0,  6'd0,  6'd0,  6'd63, 8'd255);
        offer_line(6'd63, 6'd63, 6'd63, 6'd0,  8'd200);
        offer_line(6'd0,  6'd0,  6'd63, 6'd63, 8'd255);
        offer_line(6'd0,  6'd63, 6'd63, 6'd0,  8'd255);
        offer_line(6'd10, 6'd60, 6'd20, 6'd0,  8'd255);
        offer_line(6'd0,  6'd0,  6'd63, 6'd1,  8'd255);
        offer_line(6'd63, 6'd0,  6'd0,  6'd1,  8'd255);
        offer_line(6'd0,  6'd0,  6'd40, 6'd41, 8'd170);
        offer_line(6'd41, 6'd40, 6'd0,  6'd0,  8'd85);
        offer_line(6'd5,  6'd7,  6'd50, 6'd30, 8'd0);
        offer_line(6'd5,  6'd7,  6'd50, 6'd30, 8'd1);
        offer_line(6'd0,  6'd0,  6'd63, 6'd62, 8'd255);
        offer_line(6'd1,  6'd2,  6'd4,  6'd3,  8'd254);
        offer_line(6'd62, 6'd63, 6'd63, 6'd0,  8'd255);
        offer_line(6'd42, 6'd21, 6'd21, 6'd42, 8'd127);
        offer_line(6'd63, 6'd31, 6'd32, 6'd0,  8'd99);
    endtask

    initial begin : stimulus
        logic [POS_W-1:0] canvas_w;
        logic [POS_W-1:0] canvas_h;
        int               phase;
        int               n;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The directed lines run on the reset canvas of 64 by 64.
        directed_lines();
        drain();

        // Each phase sets a new canvas while idle: above the tile, empty, full tile,
        // a single column, a single row, and finally anything at all.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       begin canvas_w = 7'd127; canvas_h = 7'd127; end
                1:       begin canvas_w = 7'd0;   canvas_h = 7'd0;   end
                2:       begin canvas_w = 7'd64;  canvas_h = 7'd64;  end
                3:       begin canvas_w = 7'd1;   canvas_h = 7'd63;  end
                4:       begin canvas_w = 7'd63;  canvas_h = 7'd1;   end
                default: begin
                    canvas_w = POS_W'($urandom_range(0, 127));
                    canvas_h = POS_W'($urandom_range(0, 127));
                end
            endcase
            apb_write(aalr_pkg::REG_CANVAS_WIDTH, canvas_w, phase[0]);
            apb_write(aalr_pkg::REG_CANVAS_HEIGHT, canvas_h, !phase[0]);

            // One phase streams without sender gaps at all.
            gaps_enabled = (phase != 3);
            // In the pressure phase the receiver holds off while the sender keeps
            // offering back to back, so the block fills and stalls its input.
            if (phase == PRESSURE_PHASE) begin
                hold_token++;
                gaps_enabled = 1'b0;
            end
            for (n = 0; n < LINES_PER_PHASE; n++) begin
                if (phase == PRESSURE_PHASE && n == 15)
                    gaps_enabled = 1'b1;
                random_line();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pairs == 0) begin
            $display("PASS antialiased_line_raster_core");
        end else begin
            $display("FAIL antialiased_line_raster_core");
        end
        $finish;
    end

endmodule

>>> files.f
design/aalr_pkg.sv
design/aalr_ctrl.sv
design/aalr_dp.sv
design/antialiased_line_raster_core.sv
verif/aalr_raster_checker.sv
verif/antialiased_line_raster_core_test.sv
